@@ design/dmb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmb_pkg
// Shared types and codes for the dual mailbox bridge.
// ----------------------------------------------------------------------------
package dmb_pkg;

    // request kinds
    localparam logic [2:0] CMD_HOST_WR  = 3'd0;
    localparam logic [2:0] CMD_HOST_RD  = 3'd1;
    localparam logic [2:0] CMD_LOCAL_WR = 3'd2;
    localparam logic [2:0] CMD_LOCAL_RD = 3'd3;
    localparam logic [2:0] CMD_TIMER_A  = 3'd4;
    localparam logic [2:0] CMD_TIMER_B  = 3'd5;

    // register offsets
    localparam logic [3:0] OFF_OUT_DATA = 4'd0;
    localparam logic [3:0] OFF_IN_DATA  = 4'd1;
    localparam logic [3:0] OFF_STATUS   = 4'd2;
    localparam logic [3:0] OFF_BITSET   = 4'd3;
    localparam logic [1:0] OFF_TCR_HI   = 2'b10;  // offsets 8..11
    localparam logic [1:0] OFF_TSR_HI   = 2'b11;  // offsets 12..15

    // bit-set selects
    localparam logic [2:0] SEL_HOST_OUT_RXEN  = 3'd4;
    localparam logic [2:0] SEL_HOST_IN_TXEN   = 3'd2;
    localparam logic [2:0] SEL_LOCAL_OUT_TXEN = 3'd6;
    localparam logic [2:0] SEL_LOCAL_IN_RXEN  = 3'd2;
    localparam logic [2:0] SEL_LOCAL_SHARED   = 3'd5;

    localparam logic [7:0] TCR_GATE_MASK = 8'hC0;
    localparam logic [7:0] TSR_FIXED     = 8'h7C;
    localparam logic [7:0] RDATA_IDLE    = 8'hFF;
    localparam int         MODE_BIT      = 7;
    localparam int         TCR_EN_A_BIT  = 2;
    localparam int         TCR_EN_B_BIT  = 3;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] reg_offset;
        logic [7:0] wdata;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       host_irq;
        logic       local_irq;
    } result_t;

endpackage

@@ design/dual_mailbox_bridge_irq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_mailbox_bridge_irq
// Host/local mailbox bridge with interrupt and timer pending state.
// ----------------------------------------------------------------------------
// Each request (host or local register access, or a timer expiry) yields one
// response holding the read byte and both interrupt levels after the request.
// One request per cycle is sustained while m_tready stays high; a request is
// held first in the input register, then the state update and read mux feed
// the response register. The response register holds while m_tready is low
// and the input register still takes a new request when the response moves
// on in the same cycle.
module dual_mailbox_bridge_irq (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] reg_offset, [11:4] wdata, [15:12] zero
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] rdata, [8] host_irq, [9] local_irq, [15:10] zero
);

    logic             in_valid_reg;
    dmb_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    dmb_pkg::result_t out_res_reg;
    dmb_pkg::result_t core_res;
    logic             fire;

    assign fire     = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | fire;

    dmb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .result  (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.cmd        <= s_tuser;
            in_item_reg.reg_offset <= s_tdata[3:0];
            in_item_reg.wdata      <= s_tdata[11:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (~out_valid_reg | m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_res_reg.local_irq, out_res_reg.host_irq,
                       out_res_reg.rdata};

endmodule

@@ design/dmb_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmb_core
// Mailbox, flag and timer state with the per-request update and read mux.
// ----------------------------------------------------------------------------
module dmb_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  dmb_pkg::item_t  item,
    output dmb_pkg::result_t result
);

    logic [7:0] in_byte_reg,  in_byte_next;
    logic       in_full_reg,  in_full_next;
    logic       in_rxen_reg,  in_rxen_next;
    logic       in_txen_reg,  in_txen_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_full_reg, out_full_next;
    logic       out_rxen_reg, out_rxen_next;
    logic       out_txen_reg, out_txen_next;
    logic       shared_reg,   shared_next;
    logic [7:0] tcr_reg,      tcr_next;
    logic [1:0] pend_reg,     pend_next;

    logic       in_rx_int, in_tx_int, out_rx_int, out_tx_int, host_src;
    logic       bitset_ok;
    logic [2:0] sel;
    logic [7:0] rdata;

    assign in_rx_int  = in_full_reg & in_rxen_reg;
    assign in_tx_int  = ~in_full_reg & in_txen_reg;
    assign out_rx_int = out_full_reg & out_rxen_reg;
    assign out_tx_int = ~out_full_reg & out_txen_reg;
    assign host_src   = (pend_reg != 2'b00) | in_tx_int | out_rx_int;

    assign bitset_ok = (item.reg_offset == dmb_pkg::OFF_BITSET)
                     & ~item.wdata[dmb_pkg::MODE_BIT];
    assign sel       = item.wdata[3:1];

    always_comb begin
        in_byte_next  = in_byte_reg;
        in_full_next  = in_full_reg;
        in_rxen_next  = in_rxen_reg;
        in_txen_next  = in_txen_reg;
        out_byte_next = out_byte_reg;
        out_full_next = out_full_reg;
        out_rxen_next = out_rxen_reg;
        out_txen_next = out_txen_reg;
        shared_next   = shared_reg;
        tcr_next      = tcr_reg;
        pend_next     = pend_reg;
        rdata         = dmb_pkg::RDATA_IDLE;

        case (item.cmd)
            dmb_pkg::CMD_HOST_WR: begin
                if (item.reg_offset == dmb_pkg::OFF_IN_DATA) begin
                    in_byte_next = item.wdata;
                    in_full_next = 1'b1;
                end else if (bitset_ok) begin
                    if (sel == dmb_pkg::SEL_HOST_OUT_RXEN) begin
                        out_rxen_next = item.wdata[0];
                    end else if (sel == dmb_pkg::SEL_HOST_IN_TXEN) begin
                        in_txen_next = item.wdata[0];
                    end
                end else if (item.reg_offset[3:2] == dmb_pkg::OFF_TCR_HI) begin
                    tcr_next  = item.wdata;
                    pend_next = pend_reg & item.wdata[1:0];
                end
            end
            dmb_pkg::CMD_HOST_RD: begin
                if (item.reg_offset == dmb_pkg::OFF_OUT_DATA) begin
                    rdata         = out_byte_reg;
                    out_full_next = 1'b0;
                end else if (item.reg_offset == dmb_pkg::OFF_IN_DATA) begin
                    rdata = in_byte_reg;
                end else if (item.reg_offset == dmb_pkg::OFF_STATUS) begin
                    rdata = {shared_reg, 1'b0, out_full_reg, out_rxen_reg,
                             out_rx_int, in_txen_reg, ~in_full_reg, in_tx_int};
                end else if (item.reg_offset[3:2] == dmb_pkg::OFF_TSR_HI) begin
                    rdata = dmb_pkg::TSR_FIXED | {host_src, 5'b00000, pend_reg};
                end
            end
            dmb_pkg::CMD_LOCAL_WR: begin
                if (item.reg_offset == dmb_pkg::OFF_OUT_DATA) begin
                    out_byte_next = item.wdata;
                    out_full_next = 1'b1;
                end else if (bitset_ok) begin
                    if (sel == dmb_pkg::SEL_LOCAL_OUT_TXEN) begin
                        out_txen_next = item.wdata[0];
                    end else if (sel == dmb_pkg::SEL_LOCAL_IN_RXEN) begin
                        in_rxen_next = item.wdata[0];
                    end else if (sel == dmb_pkg::SEL_LOCAL_SHARED) begin
                        shared_next = item.wdata[0];
                    end
                end
            end
            dmb_pkg::CMD_LOCAL_RD: begin
                if (item.reg_offset == dmb_pkg::OFF_OUT_DATA) begin
                    rdata = out_byte_reg;
                end else if (item.reg_offset == dmb_pkg::OFF_IN_DATA) begin
                    rdata        = in_byte_reg;
                    in_full_next = 1'b0;
                end else if (item.reg_offset == dmb_pkg::OFF_STATUS) begin
                    rdata = {~out_full_reg, out_txen_reg, shared_reg, 1'b0,
                             out_tx_int, in_rxen_reg, in_full_reg, in_rx_int};
                end
            end
            dmb_pkg::CMD_TIMER_A: begin
                if (tcr_reg[dmb_pkg::TCR_EN_A_BIT]) begin
                    pend_next[0] = 1'b1;
                end
            end
            dmb_pkg::CMD_TIMER_B: begin
                if (tcr_reg[dmb_pkg::TCR_EN_B_BIT]) begin
                    pend_next[1] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // interrupt levels reflect the state after this request
    always_comb begin
        result.rdata     = rdata;
        result.host_irq  = ((pend_next != 2'b00) | (~in_full_next & in_txen_next)
                           | (out_full_next & out_rxen_next))
                         & ((tcr_next & dmb_pkg::TCR_GATE_MASK) == dmb_pkg::TCR_GATE_MASK);
        result.local_irq = (in_full_next & in_rxen_next) | (~out_full_next & out_txen_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_byte_reg  <= 8'h00;
            in_full_reg  <= 1'b0;
            in_rxen_reg  <= 1'b0;
            in_txen_reg  <= 1'b0;
            out_byte_reg <= 8'h00;
            out_full_reg <= 1'b0;
            out_rxen_reg <= 1'b0;
            out_txen_reg <= 1'b0;
            shared_reg   <= 1'b0;
            tcr_reg      <= 8'h00;
            pend_reg     <= 2'b00;
        end else if (fire) begin
            in_byte_reg  <= in_byte_next;
            in_full_reg  <= in_full_next;
            in_rxen_reg  <= in_rxen_next;
            in_txen_reg  <= in_txen_next;
            out_byte_reg <= out_byte_next;
            out_full_reg <= out_full_next;
            out_rxen_reg <= out_rxen_next;
            out_txen_reg <= out_txen_next;
            shared_reg   <= shared_next;
            tcr_reg      <= tcr_next;
            pend_reg     <= pend_next;
        end
    end

endmodule

@@ sim/dual_mailbox_bridge_irq_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_mailbox_bridge_irq_test
// Self-checking bench for the host/local mailbox bridge.
// ----------------------------------------------------------------------------
// Host and local register requests plus timer expiries go in on the slave
// stream. A shadow copy of the mailbox, enable, shared flag and timer state
// predicts each untyped response; every response is compared field by field
// on the master stream. A short table of directed requests runs first, then
// weighted random traffic with random gaps and stalls on both sides.
module dual_mailbox_bridge_irq_test;

    localparam logic [2:0] CMD_SPARE_6     = 3'd6;
    localparam logic [2:0] CMD_SPARE_7     = 3'd7;
    localparam logic [3:0] OFF_RELOAD      = 4'd4;   // host timer reload, ignored
    localparam logic [3:0] OFF_UNDEF       = 4'd5;
    localparam logic [3:0] OFF_TCR         = 4'd8;
    localparam logic [3:0] OFF_LOCAL_UNDEF = 4'd9;
    localparam logic [3:0] OFF_TCR_LAST    = 4'd11;
    localparam logic [3:0] OFF_TSR         = 4'd12;
    localparam logic [3:0] OFF_TSR_LAST    = 4'd15;
    localparam logic [2:0] SEL_UNKNOWN     = 3'd7;

    localparam int RANDOM_REQS  = 1800;
    localparam int HOLD_AFTER   = 500;   // responses seen before the long hold
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 1200;  // random request where sender drains
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct {
        dmb_pkg::item_t   req;
        bit               typed;
        dmb_pkg::result_t resp;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [3:0] reg_offset, [11:4] wdata, [15:12] zero
    logic [2:0]  s_tuser  = '0;   // [2:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [7:0] rdata, [8] host_irq, [9] local_irq

    dual_mailbox_bridge_irq u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // shadow state
    logic [7:0] ib_byte, ob_byte, tcr;
    logic       ib_full, ib_rxen, ib_txen;
    logic       ob_full, ob_rxen, ob_txen;
    logic       shared_bit;
    logic [1:0] tpend;

    dmb_pkg::result_t resp_expected_q[$];
    dir_row_t directed_rows[$];
    int fail_count      = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    bit hold_done       = 1'b0;

    function automatic logic in_rx();
        return ib_full && ib_rxen;
    endfunction

    function automatic logic in_tx();
        return !ib_full && ib_txen;
    endfunction

    function automatic logic out_rx();
        return ob_full && ob_rxen;
    endfunction

    function automatic logic out_tx();
        return !ob_full && ob_txen;
    endfunction

    function automatic logic host_src();
        return (tpend != 2'b00) || in_tx() || out_rx();
    endfunction

    // Apply one request to the shadow state and return the response it causes.
    task automatic bridge_predict(input dmb_pkg::item_t req, output dmb_pkg::result_t resp);
        logic [7:0] rd;
        rd = dmb_pkg::RDATA_IDLE;
        case (req.cmd)
            dmb_pkg::CMD_HOST_WR: begin
                if (req.reg_offset == dmb_pkg::OFF_IN_DATA) begin
                    ib_byte = req.wdata;
                    ib_full = 1'b1;
                end else if (req.reg_offset == dmb_pkg::OFF_BITSET) begin
                    if (!req.wdata[dmb_pkg::MODE_BIT]) begin
                        case (req.wdata[3:1])
                            dmb_pkg::SEL_HOST_OUT_RXEN: ob_rxen = req.wdata[0];
                            dmb_pkg::SEL_HOST_IN_TXEN:  ib_txen = req.wdata[0];
                            default: ;
                        endcase
                    end
                end else if (req.reg_offset[3:2] == dmb_pkg::OFF_TCR_HI) begin
                    tcr   = req.wdata;
                    tpend = tpend & req.wdata[1:0];
                end
            end
            dmb_pkg::CMD_HOST_RD: begin
                if (req.reg_offset == dmb_pkg::OFF_OUT_DATA) begin
                    rd = ob_byte;
                    ob_full = 1'b0;
                end else if (req.reg_offset == dmb_pkg::OFF_IN_DATA) begin
                    rd = ib_byte;
                end else if (req.reg_offset == dmb_pkg::OFF_STATUS) begin
                    rd = {shared_bit, 1'b0, ob_full, ob_rxen, out_rx(), ib_txen,
                          !ib_full, in_tx()};
                end else if (req.reg_offset[3:2] == dmb_pkg::OFF_TSR_HI) begin
                    rd = dmb_pkg::TSR_FIXED | {host_src(), 5'b0, tpend};
                end
            end
            dmb_pkg::CMD_LOCAL_WR: begin
                if (req.reg_offset == dmb_pkg::OFF_OUT_DATA) begin
                    ob_byte = req.wdata;
                    ob_full = 1'b1;
                end else if (req.reg_offset == dmb_pkg::OFF_BITSET) begin
                    if (!req.wdata[dmb_pkg::MODE_BIT]) begin
                        case (req.wdata[3:1])
                            dmb_pkg::SEL_LOCAL_OUT_TXEN: ob_txen    = req.wdata[0];
                            dmb_pkg::SEL_LOCAL_IN_RXEN:  ib_rxen    = req.wdata[0];
                            dmb_pkg::SEL_LOCAL_SHARED:   shared_bit = req.wdata[0];
                            default: ;
                        endcase
                    end
                end
            end
            dmb_pkg::CMD_LOCAL_RD: begin
                if (req.reg_offset == dmb_pkg::OFF_OUT_DATA) begin
                    rd = ob_byte;
                end else if (req.reg_offset == dmb_pkg::OFF_IN_DATA) begin
                    rd = ib_byte;
                    ib_full = 1'b0;
                end else if (req.reg_offset == dmb_pkg::OFF_STATUS) begin
                    rd = {!ob_full, ob_txen, shared_bit, 1'b0, out_tx(), ib_rxen,
                          ib_full, in_rx()};
                end
            end
            dmb_pkg::CMD_TIMER_A: if (tcr[dmb_pkg::TCR_EN_A_BIT]) tpend[0] = 1'b1;
            dmb_pkg::CMD_TIMER_B: if (tcr[dmb_pkg::TCR_EN_B_BIT]) tpend[1] = 1'b1;
            default: ;
        endcase
        resp.rdata     = rd;
        resp.host_irq  = host_src()
                         && ((tcr & dmb_pkg::TCR_GATE_MASK) == dmb_pkg::TCR_GATE_MASK);
        resp.local_irq = in_rx() || out_tx();
    endtask

    function automatic dir_row_t mk_row(logic [2:0] cmd, logic [3:0] off, logic [7:0] wd,
                                        bit typed, logic [7:0] rd, logic hi, logic li);
        dir_row_t row;
        row.req.cmd        = cmd;
        row.req.reg_offset = off;
        row.req.wdata      = wd;
        row.typed          = typed;
        row.resp.rdata     = rd;
        row.resp.host_irq  = hi;
        row.resp.local_irq = li;
        return row;
    endfunction

    function automatic logic [7:0] bitset(logic [2:0] sel, logic b);
        return {1'b0, 3'b000, sel, b};
    endfunction

    // mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic dmb_pkg::item_t rand_item();
        dmb_pkg::item_t req;
        int p;
        p = $urandom_range(0, 99);
        if (p < 4) begin
            req.cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
        end else begin
            p = $urandom_range(0, 19);
            if (p < 5)       req.cmd = dmb_pkg::CMD_HOST_WR;
            else if (p < 9)  req.cmd = dmb_pkg::CMD_HOST_RD;
            else if (p < 14) req.cmd = dmb_pkg::CMD_LOCAL_WR;
            else if (p < 18) req.cmd = dmb_pkg::CMD_LOCAL_RD;
            else if (p < 19) req.cmd = dmb_pkg::CMD_TIMER_A;
            else             req.cmd = dmb_pkg::CMD_TIMER_B;
        end
        if ($urandom_range(0, 3) == 0) begin
            req.reg_offset = 4'($urandom_range(0, 15));
        end else begin
            case ($urandom_range(0, 4))
                0: req.reg_offset = dmb_pkg::OFF_OUT_DATA;
                1: req.reg_offset = dmb_pkg::OFF_IN_DATA;
                2: req.reg_offset = dmb_pkg::OFF_STATUS;
                3: req.reg_offset = dmb_pkg::OFF_BITSET;
                default: req.reg_offset = 4'($urandom_range(8, 15));
            endcase
        end
        req.wdata = 8'($urandom);
        // most bit-set requests are well formed, the rest keep a random mode bit
        if (req.reg_offset == dmb_pkg::OFF_BITSET && $urandom_range(0, 7) != 0)
            req.wdata[dmb_pkg::MODE_BIT] = 1'b0;
        // force the host IRQ gate bits open on about half of the host TCR writes
        if (req.cmd == dmb_pkg::CMD_HOST_WR && req.reg_offset[3:2] == dmb_pkg::OFF_TCR_HI
            && $urandom_range(0, 1) == 1)
            req.wdata[7:6] = 2'b11;
        return req;
    endfunction

    task automatic offer(input dmb_pkg::item_t req, input bit typed,
                         input dmb_pkg::result_t typed_resp, input bit calm);
        dmb_pkg::result_t pred;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req.cmd;
        s_tdata  <= {4'h0, req.wdata, req.reg_offset};
        do @(posedge aclk); while (!s_tready);
        bridge_predict(req, pred);
        resp_expected_q.push_back(typed ? typed_resp : pred);
        requests_sent++;
        gap = (calm || $urandom_range(0, 1) == 1) ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // response checker
    always @(posedge aclk) begin
        dmb_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (resp_expected_q.size() == 0) begin
                $error("unexpected response %h", m_tdata);
                fail_count++;
            end else begin
                want = resp_expected_q.pop_front();
                if (m_tdata[7:0] !== want.rdata) begin
                    $error("rdata: expected %h, got %h", want.rdata, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[8] !== want.host_irq) begin
                    $error("host_irq: expected %b, got %b", want.host_irq, m_tdata[8]);
                    fail_count++;
                end
                if (m_tdata[9] !== want.local_irq) begin
                    $error("local_irq: expected %b, got %b", want.local_irq, m_tdata[9]);
                    fail_count++;
                end
            end
        end
    end

    // response side backpressure
    initial begin
        int stall;
        int cyc;
        stall = 0;
        cyc   = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            cyc++;
            if (!hold_done && results_checked >= HOLD_AFTER) begin
                // long hold while the sender keeps pushing, fills the pipe
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if ((cyc % 1000) < 150) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall = gap_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // request side
    initial begin
        dmb_pkg::item_t   req;
        dmb_pkg::result_t none;
        int               waited;
        bit               timed_out;
        none = '0;
        timed_out = 1'b0;
        ib_byte = '0; ib_full = 1'b0; ib_rxen = 1'b0; ib_txen = 1'b0;
        ob_byte = '0; ob_full = 1'b0; ob_rxen = 1'b0; ob_txen = 1'b0;
        shared_bit = 1'b0; tcr = '0; tpend = '0;

        // reset values, extremes, ignored writes, every bit-set select, mailbox data, timer events, status reads
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_RD, dmb_pkg::OFF_STATUS, 8'h00,
                                       1'b1, 8'h02, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_LOCAL_RD, dmb_pkg::OFF_STATUS, 8'h00,
                                       1'b1, 8'h80, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_RD, OFF_TSR, 8'h00,
                                       1'b1, dmb_pkg::TSR_FIXED, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_RD, OFF_UNDEF, 8'h00,
                                       1'b1, dmb_pkg::RDATA_IDLE, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_LOCAL_RD, OFF_LOCAL_UNDEF, 8'h00,
                                       1'b1, dmb_pkg::RDATA_IDLE, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CMD_SPARE_6, dmb_pkg::OFF_IN_DATA, 8'h00,
                                       1'b1, dmb_pkg::RDATA_IDLE, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(CMD_SPARE_7, OFF_TSR_LAST, 8'hFF,
                                       1'b1, dmb_pkg::RDATA_IDLE, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_WR, dmb_pkg::OFF_IN_DATA, 8'hFF,
                                       1'b1, dmb_pkg::RDATA_IDLE, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_LOCAL_WR, dmb_pkg::OFF_BITSET,
                                       bitset(dmb_pkg::SEL_LOCAL_IN_RXEN, 1'b1),
                                       1'b1, dmb_pkg::RDATA_IDLE, 1'b0, 1'b1));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_LOCAL_RD, dmb_pkg::OFF_IN_DATA, 8'h00,
                                       1'b1, 8'hFF, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_WR, dmb_pkg::OFF_IN_DATA, 8'h00,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_WR, dmb_pkg::OFF_BITSET,
                                       8'h80 | bitset(dmb_pkg::SEL_HOST_OUT_RXEN, 1'b1),
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_WR, dmb_pkg::OFF_BITSET,
                                       bitset(SEL_UNKNOWN, 1'b1),
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_WR, dmb_pkg::OFF_BITSET,
                                       bitset(dmb_pkg::SEL_HOST_OUT_RXEN, 1'b1),
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_WR, dmb_pkg::OFF_BITSET,
                                       bitset(dmb_pkg::SEL_HOST_IN_TXEN, 1'b1),
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_LOCAL_WR, dmb_pkg::OFF_OUT_DATA, 8'hA5,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_WR, OFF_TCR, 8'hCC,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_TIMER_A, dmb_pkg::OFF_OUT_DATA, 8'h00,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_TIMER_B, dmb_pkg::OFF_OUT_DATA, 8'h00,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_RD, OFF_TSR_LAST, 8'h00,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_WR, OFF_RELOAD, 8'h55,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_LOCAL_RD, dmb_pkg::OFF_OUT_DATA, 8'h00,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_RD, dmb_pkg::OFF_OUT_DATA, 8'h00,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_LOCAL_WR, dmb_pkg::OFF_BITSET,
                                       bitset(dmb_pkg::SEL_LOCAL_OUT_TXEN, 1'b1),
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_LOCAL_WR, dmb_pkg::OFF_BITSET,
                                       bitset(dmb_pkg::SEL_LOCAL_SHARED, 1'b1),
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_RD, dmb_pkg::OFF_STATUS, 8'h00,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_LOCAL_RD, dmb_pkg::OFF_STATUS, 8'h00,
                                       1'b0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(dmb_pkg::CMD_HOST_WR, OFF_TCR_LAST, 8'h00,
                                       1'b0, 8'h00, 1'b0, 1'b0));

        while (!aresetn) @(posedge aclk);
        @(posedge aclk);

        foreach (directed_rows[i])
            offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].resp, 1'b0);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == DRAIN_AT) begin
                // sender goes quiet until every response is back
                s_tvalid <= 1'b0;
                while (resp_expected_q.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
            req = rand_item();
            offer(req, 1'b0, none, (n % 300) < 60);
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (resp_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (resp_expected_q.size() != 0)
            timed_out = 1'b1;

        if (timed_out) begin
            $display("[FAIL] regression broken");
        end else begin
            repeat (10) @(posedge aclk);
            $display("sent %0d requests (%0d from the directed table), checked %0d responses",
                     requests_sent, directed_rows.size(), results_checked);
            $display("covered host/local mailbox traffic, bit-set selects, timer events, stalls");
            if (fail_count == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
